/* sv/b64enc_pkg.sv */
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64enc_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // phases of a 3-byte group
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // characters produced by one input byte, oldest in chars[0]
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            is_final;
   } entry_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      begin
         if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
         end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
         end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
         end else if (v == 6'd62) begin
            c = 8'h2B;
         end else begin
            c = 8'h2F;
         end
         return c;
      end
   endfunction

endpackage

/* sv/b64enc_front.sv */
// front end: accepts bytes, tracks the group phase and builds character entries
module b64enc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_final_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output b64enc_pkg::entry_type q_entry
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;

   assign q_push = req_push && !q_full;

   always_comb begin
      q_entry          = '0;
      q_entry.is_final = req_final_byte;
      phase_in         = phase_ff;
      leftover_in      = leftover_ff;
      case (phase_ff)
         b64enc_pkg::PHASE_SECOND: begin
            q_entry.chars[0] = b64enc_pkg::sextet_char({leftover_ff[1:0], req_data_byte[7:4]});
            q_entry.chars[1] = b64enc_pkg::sextet_char({req_data_byte[3:0], 2'b00});
            q_entry.chars[2] = b64enc_pkg::PAD_CHAR;
            q_entry.last_idx = req_final_byte ? 2'd2 : 2'd0;
            phase_in         = b64enc_pkg::PHASE_THIRD;
            leftover_in      = req_data_byte[3:0];
         end
         b64enc_pkg::PHASE_THIRD: begin
            q_entry.chars[0] = b64enc_pkg::sextet_char({leftover_ff, req_data_byte[7:6]});
            q_entry.chars[1] = b64enc_pkg::sextet_char(req_data_byte[5:0]);
            q_entry.last_idx = 2'd1;
            phase_in         = b64enc_pkg::PHASE_FIRST;
            leftover_in      = '0;
         end
         default: begin
            q_entry.chars[0] = b64enc_pkg::sextet_char(req_data_byte[7:2]);
            q_entry.chars[1] = b64enc_pkg::sextet_char({req_data_byte[1:0], 4'b0000});
            q_entry.chars[2] = b64enc_pkg::PAD_CHAR;
            q_entry.chars[3] = b64enc_pkg::PAD_CHAR;
            q_entry.last_idx = req_final_byte ? 2'd3 : 2'd0;
            phase_in         = b64enc_pkg::PHASE_SECOND;
            leftover_in      = {2'b00, req_data_byte[1:0]};
         end
      endcase
      // end of message: flush done, start a fresh group
      if (req_final_byte) begin
         phase_in    = b64enc_pkg::PHASE_FIRST;
         leftover_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= b64enc_pkg::PHASE_FIRST;
         leftover_ff <= '0;
      end else if (q_push) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

/* sv/b64enc_queue.sv */
// short entry queue between the front end and the character serializer
module b64enc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output b64enc_pkg::entry_type pop_entry,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64enc_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* sv/b64enc_back.sv */
// back end: holds one entry and hands out its characters one per transfer
module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  b64enc_pkg::entry_type q_entry,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_code_char,
   output logic                  rsp_final_char
);

   b64enc_pkg::entry_type cur_ff;
   logic                  valid_ff;
   logic [1:0]            idx_ff;
   logic                  at_last, done, load;

   assign at_last        = (idx_ff == cur_ff.last_idx);
   assign done           = rsp_pop && valid_ff && at_last;
   assign load           = !valid_ff || done;
   assign q_pop          = load && !q_empty;
   assign rsp_empty      = !valid_ff;
   assign rsp_code_char  = cur_ff.chars[idx_ff];
   assign rsp_final_char = cur_ff.is_final && at_last;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= !q_empty;
         idx_ff   <= '0;
      end else if (rsp_pop) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= cur_ff.last_idx)
      else $error("character index ran past the end of its entry");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> idx_ff == 2'd0)
      else $error("index not cleared while no entry is held");

   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && valid_ff && !at_last) |=> valid_ff && idx_ff == $past(idx_ff) + 2'd1)
      else $error("mid-entry transfer did not advance to the next character");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      (done && !q_empty) |=> valid_ff && idx_ff == 2'd0)
      else $error("finished entry not replaced by the waiting one");

endmodule

/* sv/base64_stream_encoder.sv */
// top level of the streaming base64 encoder
//
// input side: a queue-style byte channel. a byte and its end-of-message flag
// transfer when req_push is high and req_full is low; the block takes one
// byte every cycle as long as its entry queue has room.
// output side: a queue-style character channel. while rsp_empty is low the
// oldest character sits on rsp_code_char, with rsp_final_char high on the
// last character of a message; it transfers when rsp_pop is high.
// each byte turns into one entry of one to four characters (two at the end
// of a group, up to four at the flush of a final byte with '=' padding).
// the first character of a byte shows once the byte has passed the entry
// queue and then the serializer register, when both are idle.
// the serializer gives one character per cycle while rsp_pop is high and
// the queue holds entries, so it, not the byte intake, sets the pace (3
// bytes, 4 characters).
// a stalled receiver holds the current character; bytes keep arriving until
// the QUEUE_DEPTH entry queue fills, then req_full rises.
// reset clears the group phase, the queue and the serializer; no character
// is left waiting afterwards.
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // byte channel
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   // character channel
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_code_char,
   output logic       rsp_final_char
);

   b64enc_pkg::entry_type push_entry, pop_entry;
   logic                  q_push, q_full, q_pop, q_empty;

   // queue full is the only reason to refuse a byte
   assign req_full = q_full;

   // front end: group phase and leftover bits, one entry per byte
   b64enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // entry queue decouples byte intake from character output
   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // serializer: one character per transfer
   b64enc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_entry        (pop_entry),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_code_char  (rsp_code_char),
      .rsp_final_char (rsp_final_char)
   );

endmodule
